// File: rtl/multi_mode_byte_crc_assert.svh
// Assertion macros shared by the CRC engine RTL.
// Used by multi_mode_byte_crc.sv; needs nothing else.
`ifndef MULTI_MODE_BYTE_CRC_ASSERT_SVH
`define MULTI_MODE_BYTE_CRC_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MCRC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mcrc same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define MCRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mcrc next-cycle check failed");

`endif

// File: rtl/mcrc_pkg.sv
// Package for the multi-mode byte CRC engine: mode codes and polynomials.
// No dependencies; imported by mcrc_fold and multi_mode_byte_crc.
package mcrc_pkg;

   typedef enum logic [1:0] {
      MODE_MODBUS = 2'd0,
      MODE_CRC8   = 2'd1,
      MODE_XMODEM = 2'd2
   } crc_mode_type;

   localparam logic [15:0] MODBUS_POLY = 16'hA001;
   localparam logic [15:0] MODBUS_INIT = 16'hFFFF;
   localparam logic [7:0]  CRC8_POLY   = 8'h8C;
   localparam logic [7:0]  CRC8_INIT   = 8'h00;
   localparam logic [15:0] XMODEM_POLY = 16'h1021;
   localparam logic [15:0] XMODEM_INIT = 16'h0000;

endpackage

// File: rtl/multi_mode_byte_crc.sv
// Top level of the multi-mode byte CRC engine: input stage, running CRC, result register.
// Depends on mcrc_pkg, mcrc_fold and multi_mode_byte_crc_assert.svh.
//
//   Port group  Direction  Beat contents
//   req_        in         tdata[7:0] data_byte, tuser is_first, tlast is_last
//   rsp_        out        tdata[15:0] crc_value (CRC-8 result in bits 7..0)
//   csr_        in         wr_data[1:0] crc_mode, written when wr_en is high
//
// The engine takes one byte per cycle unless a last byte stalls; the combinational fold
// of the stored CRC sets this rate. A byte is registered on acceptance, folded into the
// running CRC as it leaves the input stage, and a last byte's CRC is then held for rsp_.
// Reset (synchronous, active high) selects Modbus mode and clears the running CRC.
// While a finished CRC waits on rsp_, bytes that are not last keep flowing; only a
// further last byte stalls the input until the waiting result is taken.
module multi_mode_byte_crc
   import mcrc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Input channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] is_first
   input  logic        req_tlast,   // is_last
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] crc_value
   // Configuration.
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data  // [1:0] crc_mode
);

   // Mode register.
   logic [1:0]  mode_ff;
   logic [1:0]  mode_in;

   // Input stage: one registered byte with its flags.
   logic        stg_valid_ff;
   logic        stg_valid_in;
   logic [7:0]  stg_byte_ff;
   logic        stg_first_ff;
   logic        stg_last_ff;

   // Running CRC and result register.
   logic [15:0] running_crc_ff;
   logic [15:0] running_crc_in;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [15:0] rsp_data_ff;

   logic        req_fire;
   logic        stg_fire;
   logic        out_free;
   logic [15:0] fold_crc;

   assign mode_in = csr_wr_en ? csr_wr_data : mode_ff;

   // The result slot is free when empty or being emptied this cycle.
   assign out_free = !rsp_valid_ff || rsp_tready;
   // A byte that is not last never needs the result slot.
   assign stg_fire   = stg_valid_ff && (!stg_last_ff || out_free);
   assign req_tready = !stg_valid_ff || stg_fire;
   assign req_fire   = req_tvalid && req_tready;

   assign stg_valid_in   = req_fire ? 1'b1 : (stg_fire ? 1'b0 : stg_valid_ff);
   assign running_crc_in = stg_fire ? fold_crc : running_crc_ff;
   assign rsp_valid_in   = (stg_fire && stg_last_ff) ? 1'b1
                         : (rsp_tready ? 1'b0 : rsp_valid_ff);

   mcrc_fold u_fold (
      .mode      (mode_ff),
      .crc_in    (running_crc_ff),
      .data_byte (stg_byte_ff),
      .is_first  (stg_first_ff),
      .crc_out   (fold_crc)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= 2'(MODE_MODBUS);
         stg_valid_ff   <= 1'b0;
         running_crc_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         mode_ff        <= mode_in;
         stg_valid_ff   <= stg_valid_in;
         running_crc_ff <= running_crc_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         stg_byte_ff  <= req_tdata;
         stg_first_ff <= req_tuser;
         stg_last_ff  <= req_tlast;
      end
      if (stg_fire && stg_last_ff) begin
         rsp_data_ff <= fold_crc;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`include "multi_mode_byte_crc_assert.svh"

   // A last byte leaving the input stage always produces a result beat.
   `MCRC_ASSERT_NEXT(a_last_makes_result, clock, reset, stg_fire && stg_last_ff, rsp_valid_ff)

   // A last byte stuck behind a waiting result blocks the input.
   `MCRC_ASSERT_SAME(a_last_stalls_input, clock, reset,
      stg_valid_ff && stg_last_ff && rsp_valid_ff && !rsp_tready, !req_tready)

   // A byte that is not last neither creates nor drops a result.
   `MCRC_ASSERT_NEXT(a_inner_no_result, clock, reset,
      stg_fire && !stg_last_ff, rsp_valid_ff == $past(rsp_valid_ff && !rsp_tready))

endmodule

// File: rtl/mcrc_fold.sv
// Combinational fold of one byte into the running CRC for all three modes.
// Depends on mcrc_pkg for mode codes and polynomials.
module mcrc_fold
   import mcrc_pkg::*;
(
   input  logic [1:0]  mode,
   input  logic [15:0] crc_in,
   input  logic [7:0]  data_byte,
   input  logic        is_first,
   output logic [15:0] crc_out
);

   always_comb begin
      logic [15:0] c16;
      logic [7:0]  c8;
      c16     = '0;
      c8      = '0;
      crc_out = '0;
      case (mode)
         MODE_CRC8: begin
            c8 = (is_first ? CRC8_INIT : crc_in[7:0]) ^ data_byte;
            for (int k = 0; k < 8; k++) begin
               c8 = c8[0] ? ((c8 >> 1) ^ CRC8_POLY) : (c8 >> 1);
            end
            crc_out = {8'h00, c8};
         end
         MODE_XMODEM: begin
            c16 = (is_first ? XMODEM_INIT : crc_in) ^ {data_byte, 8'h00};
            for (int k = 0; k < 8; k++) begin
               c16 = c16[15] ? ((c16 << 1) ^ XMODEM_POLY) : (c16 << 1);
            end
            crc_out = c16;
         end
         default: begin
            // Modbus, and the unused fourth code, which behaves the same.
            c16 = (is_first ? MODBUS_INIT : crc_in) ^ {8'h00, data_byte};
            for (int k = 0; k < 8; k++) begin
               c16 = c16[0] ? ((c16 >> 1) ^ MODBUS_POLY) : (c16 >> 1);
            end
            crc_out = c16;
         end
      endcase
   end

endmodule
